// ===== rtl/raw12_pkg.sv =====
`default_nettype none

package raw12_pkg;

  // Field widths fixed by the stream format
  localparam int BYTE_W      = 8;
  localparam int PIX_W       = 8;
  localparam int PLANE_W     = 2;
  localparam int PIX_IDX_W   = 24;
  localparam int CFG_DATA_W  = 14;
  localparam int CFG_IDX_W   = 1;
  localparam int NIBBLE_W    = 4;

  // Default size limits
  localparam int DEF_MAX_WIDTH  = 8192;
  localparam int DEF_MAX_HEIGHT = 8192;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] ROW_WIDTH_RST  = 14'd4096;
  localparam logic [CFG_DATA_W-1:0] FRAME_ROWS_RST = 14'd3072;

  typedef logic [BYTE_W-1:0]     byte_t;
  typedef logic [PIX_W-1:0]      pix_t;
  typedef logic [PLANE_W-1:0]    plane_t;
  typedef logic [PIX_IDX_W-1:0]  pix_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [NIBBLE_W-1:0]   nibble_t;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_WIDTH  = 1'b0,
    CFG_FRAME_ROWS = 1'b1
  } cfg_idx_t;

  // Bayer plane codes
  localparam plane_t PLANE_RED     = 2'd0;
  localparam plane_t PLANE_GREEN_R = 2'd1;
  localparam plane_t PLANE_GREEN_B = 2'd2;
  localparam plane_t PLANE_BLUE    = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/raw12_ifs.sv =====
`default_nettype none

// Packed sensor byte stream
interface raw12_byte_if;
  import raw12_pkg::*;
  logic  valid;
  logic  ready;
  byte_t data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// Unpacked, plane-tagged pixel stream
interface raw12_pix_if;
  import raw12_pkg::*;
  logic     valid;
  logic     ready;
  pix_t     pixel_value;
  plane_t   plane;
  pix_idx_t plane_index;
  logic     frame_last;

  modport source (output valid, output pixel_value, output plane, output plane_index,
                  output frame_last, input ready);
  modport sink   (input valid, input pixel_value, input plane, input plane_index,
                  input frame_last, output ready);
endinterface

// Register write channel
interface raw12_cfg_if;
  import raw12_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/raw12_unpack_bayer_plane_split.sv =====
// RAW12 Bayer unpacker and plane splitter.
//
// byte_stream carries the packed big-endian 12-bit sensor data, one byte per
// item, three bytes for two pixels. pixel_stream gives one item per pixel:
// the upper eight bits, the Bayer plane, the index within that quarter plane
// and a flag on the last pixel of the frame. The middle byte of a triplet
// gives no pixel; its low nibble is held for the second pixel.
// cfg writes row_width (index 0) and frame_rows (index 1); it is always
// ready and takes one write per cycle. Write it only while the block is idle.
//
// Pixel valid rises in the cycle after a pixel byte is accepted. One byte
// is taken every cycle unless the receiver stalls: the unpack and counter
// update sit between the accepted byte and a single output register.
// When the receiver stalls, the output register holds its pixel and
// byte_stream.ready drops only while that register is full and not taken.
// Synchronous reset loads the register defaults, clears the counters, the
// byte phase and the output valid.
`default_nettype none

module raw12_unpack_bayer_plane_split #(
  parameter int MAX_WIDTH  = raw12_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = raw12_pkg::DEF_MAX_HEIGHT
) (
  input  wire           clk,
  input  wire           rst,
  raw12_byte_if.sink    byte_stream,
  raw12_pix_if.source   pixel_stream,
  raw12_cfg_if.sink     cfg
);
  import raw12_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int DIMW = CFG_DATA_W + 1;
  localparam logic [DIMW-1:0] MaxWEven = DIMW'(MAX_WIDTH & ~1);
  localparam logic [DIMW-1:0] MaxH     = DIMW'(MAX_HEIGHT);

  typedef enum logic [2:0] {
    PH_FIRST = 3'b001,
    PH_MID   = 3'b010,
    PH_LAST  = 3'b100
  } phase_t;

  // Registers
  cfg_data_t row_width, frame_rows;
  phase_t    phase, phase_next;
  nibble_t   held_nibble, held_nibble_next;
  logic [CW-1:0] col_count, col_count_next;
  logic [RW-1:0] row_count, row_count_next;
  pix_idx_t  even_pairs, even_pairs_next;
  pix_idx_t  odd_pairs, odd_pairs_next;

  logic      out_valid;
  pix_t      out_pixel, out_pixel_next;
  plane_t    out_plane, out_plane_next;
  pix_idx_t  out_index, out_index_next;
  logic      out_last, out_last_next;

  logic in_fire, emit;
  logic odd_row, row_end, frame_end;
  logic [DIMW-1:0] w_raw, w_eff, r_raw, r_eff;

  assign in_fire           = byte_stream.valid && byte_stream.ready;
  assign byte_stream.ready = !out_valid || pixel_stream.ready;
  assign cfg.ready         = 1'b1;

  assign pixel_stream.valid       = out_valid;
  assign pixel_stream.pixel_value = out_pixel;
  assign pixel_stream.plane       = out_plane;
  assign pixel_stream.plane_index = out_index;
  assign pixel_stream.frame_last  = out_last;

  // Effective frame size, clamped
  always_comb begin
    w_raw = {1'b0, row_width[CFG_DATA_W-1:1], 1'b0};
    w_eff = w_raw;
    if (w_raw < DIMW'(2)) w_eff = DIMW'(2);
    if (w_raw > MaxWEven) w_eff = MaxWEven;
    r_raw = {1'b0, frame_rows};
    r_eff = r_raw;
    if (r_raw < DIMW'(1)) r_eff = DIMW'(1);
    if (r_raw > MaxH) r_eff = MaxH;
  end

  assign odd_row   = row_count[0];
  assign row_end   = DIMW'(col_count) >= (w_eff - DIMW'(1));
  assign frame_end = row_end && (DIMW'(row_count) >= (r_eff - DIMW'(1)));

  // Unpack and counter update for one byte
  always_comb begin
    phase_next       = phase;
    held_nibble_next = held_nibble;
    col_count_next   = col_count;
    row_count_next   = row_count;
    even_pairs_next  = even_pairs;
    odd_pairs_next   = odd_pairs;
    emit             = 1'b0;
    out_pixel_next   = byte_stream.data_byte;
    out_plane_next   = odd_row ? PLANE_GREEN_B : PLANE_RED;
    out_index_next   = odd_row ? odd_pairs : even_pairs;
    out_last_next    = 1'b0;
    unique case (phase)
      PH_FIRST: begin
        emit           = 1'b1;
        col_count_next = col_count + CW'(1);
        phase_next     = PH_MID;
      end
      PH_MID: begin
        held_nibble_next = byte_stream.data_byte[NIBBLE_W-1:0];
        phase_next       = PH_LAST;
      end
      PH_LAST: begin
        emit           = 1'b1;
        out_pixel_next = {held_nibble, byte_stream.data_byte[BYTE_W-1 -: NIBBLE_W]};
        out_plane_next = odd_row ? PLANE_BLUE : PLANE_GREEN_R;
        out_last_next  = frame_end;
        if (odd_row) odd_pairs_next  = odd_pairs + PIX_IDX_W'(1);
        else         even_pairs_next = even_pairs + PIX_IDX_W'(1);
        if (frame_end) begin
          col_count_next  = '0;
          row_count_next  = '0;
          even_pairs_next = '0;
          odd_pairs_next  = '0;
        end else if (row_end) begin
          col_count_next = '0;
          row_count_next = row_count + RW'(1);
        end else begin
          col_count_next = col_count + CW'(1);
        end
        phase_next = PH_FIRST;
      end
      default: begin
        phase_next = PH_FIRST;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width  <= ROW_WIDTH_RST;
      frame_rows <= FRAME_ROWS_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_ROW_WIDTH:  row_width  <= cfg.data;
        CFG_FRAME_ROWS: frame_rows <= cfg.data;
        default: ;
      endcase
    end
  end

  // Stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_FIRST;
      held_nibble <= '0;
      col_count   <= '0;
      row_count   <= '0;
      even_pairs  <= '0;
      odd_pairs   <= '0;
    end else if (in_fire) begin
      phase       <= phase_next;
      held_nibble <= held_nibble_next;
      col_count   <= col_count_next;
      row_count   <= row_count_next;
      even_pairs  <= even_pairs_next;
      odd_pairs   <= odd_pairs_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid <= 1'b1;
    end else if (pixel_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_pixel <= out_pixel_next;
      out_plane <= out_plane_next;
      out_index <= out_index_next;
      out_last  <= out_last_next;
    end
  end

  // Frame end only on the second pixel of a pair
  a_last_on_second: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_plane[0])
    else $error("frame_last on first pixel of a pair");

  // A new pixel appears only after a byte that yields one
  a_rise_needs_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_fire) && ($past(phase) != PH_MID))
    else $error("pixel valid without a pixel byte");

  // Column never passes the widest row
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    DIMW'(col_count) <= MaxWEven - DIMW'(1))
    else $error("column count out of range");

  // Frame end clears all position counters
  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    in_fire && (phase == PH_LAST) && frame_end |=>
      (col_count == '0) && (row_count == '0) && (even_pairs == '0) && (odd_pairs == '0))
    else $error("counters not cleared at frame end");

endmodule

`default_nettype wire

// ===== tb/tb_raw12_unpack_bayer_plane_split.sv =====
`default_nettype none

module tb_raw12_unpack_bayer_plane_split;
  timeunit 1ns;
  timeprecision 1ps;
  import raw12_pkg::*;

  // Pending stimulus: bytes, register writes and settle points between phases
  typedef enum logic [1:0] {
    STIM_BYTE,
    STIM_REG,
    STIM_SETTLE
  } stim_kind_t;

  typedef struct {
    stim_kind_t kind;
    cfg_idx_t   reg_idx;
    cfg_data_t  value;
  } stim_op_t;

  typedef struct {
    pix_t     value;
    plane_t   plane;
    pix_idx_t plane_index;
    logic     frame_last;
  } pixel_t;

  localparam int SETTLE_CYCLES = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;

  raw12_byte_if byte_if ();
  raw12_pix_if  pix_if ();
  raw12_cfg_if  cfg_if ();

  raw12_unpack_bayer_plane_split dut (
    .clk          (clk),
    .rst          (rst),
    .byte_stream  (byte_if),
    .pixel_stream (pix_if),
    .cfg          (cfg_if)
  );

  stim_op_t stim_q[$];
  pixel_t   pixels_due[$];
  int       errors = 0;

  // Predictor state
  cfg_data_t   width_reg;
  cfg_data_t   rows_reg;
  int unsigned triplet_pos;
  nibble_t     held_nib;
  int unsigned col_pos;
  int unsigned row_pos;
  pix_idx_t    even_pairs;
  pix_idx_t    odd_pairs;

  // Handshake flags sampled at the rising edge, used by the driver at the falling edge
  bit byte_acc = 0;
  bit cfg_acc  = 0;

  // Driver state
  bit          byte_busy = 0;
  bit          cfg_busy  = 0;
  byte_t       cur_byte  = '0;
  cfg_idx_t    cur_idx   = CFG_ROW_WIDTH;
  cfg_data_t   cur_value = '0;
  int unsigned gap_left  = 0;
  int unsigned settle_cnt = 0;
  bit          src_idling = 1;
  bit          snk_stalls = 1;
  int unsigned stall_left = 0;

  always #6 clk = ~clk;

  initial begin
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    pix_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CFG_ROW_WIDTH;
    cfg_if.data       = '0;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_byte(input byte_t b);
    stim_op_t op;
    op.kind    = STIM_BYTE;
    op.reg_idx = CFG_ROW_WIDTH;
    op.value   = cfg_data_t'(b);
    stim_q.push_back(op);
  endtask

  task automatic push_reg(input cfg_idx_t idx, input cfg_data_t v);
    stim_op_t op;
    op.kind    = STIM_REG;
    op.reg_idx = idx;
    op.value   = v;
    stim_q.push_back(op);
  endtask

  // Wait for the block to drain, then switch idling mode (bit 0 source, bit 1 sink)
  task automatic push_settle(input int unsigned mode);
    stim_op_t op;
    op.kind    = STIM_SETTLE;
    op.reg_idx = CFG_ROW_WIDTH;
    op.value   = cfg_data_t'(mode);
    stim_q.push_back(op);
  endtask

  task automatic apply_reg_write(input cfg_idx_t idx, input cfg_data_t v);
    case (idx)
      CFG_ROW_WIDTH:  width_reg = v;
      CFG_FRAME_ROWS: rows_reg  = v;
      default: ;
    endcase
  endtask

  // Unpack one accepted byte; first and third byte of a triplet give a pixel
  task automatic unpack_byte(input byte_t b);
    pixel_t      px;
    int unsigned w;
    int unsigned r;
    bit          odd_row;
    bit          row_end;
    bit          frame_end;
    odd_row        = row_pos[0];
    px.plane_index = odd_row ? odd_pairs : even_pairs;
    px.frame_last  = 1'b0;
    case (triplet_pos)
      0: begin
        px.value = b;
        px.plane = odd_row ? PLANE_GREEN_B : PLANE_RED;
        pixels_due.push_back(px);
        col_pos     = (col_pos + 1) & 32'h7FFF;
        triplet_pos = 1;
      end
      1: begin
        held_nib    = b[3:0];
        triplet_pos = 2;
      end
      default: begin
        w = 32'(width_reg & 14'h3FFE);
        if (w < 2) w = 2;
        if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
        r = 32'(rows_reg);
        if (r < 1) r = 1;
        if (r > DEF_MAX_HEIGHT) r = DEF_MAX_HEIGHT;
        row_end   = col_pos >= w - 1;
        frame_end = row_end && (row_pos >= r - 1);
        px.value      = {held_nib, b[7:4]};
        px.plane      = odd_row ? PLANE_BLUE : PLANE_GREEN_R;
        px.frame_last = frame_end;
        pixels_due.push_back(px);
        if (odd_row) odd_pairs = odd_pairs + 1'b1;
        else even_pairs = even_pairs + 1'b1;
        if (frame_end) begin
          col_pos    = 0;
          row_pos    = 0;
          even_pairs = '0;
          odd_pairs  = '0;
        end else if (row_end) begin
          col_pos = 0;
          row_pos = (row_pos + 1) & 32'h7FFF;
        end else begin
          col_pos = (col_pos + 1) & 32'h7FFF;
        end
        triplet_pos = 0;
      end
    endcase
  endtask

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0h got %0h", $time, name, want, got);
    end
  endtask

  // Monitor: predictor update on accepted bytes and writes, pixel check
  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      width_reg   = ROW_WIDTH_RST;
      rows_reg    = FRAME_ROWS_RST;
      triplet_pos = 0;
      held_nib    = '0;
      col_pos     = 0;
      row_pos     = 0;
      even_pairs  = '0;
      odd_pairs   = '0;
      byte_acc    = 0;
      cfg_acc     = 0;
    end else begin
      byte_acc = byte_if.valid && byte_if.ready;
      cfg_acc  = cfg_if.valid && cfg_if.ready;
      if (cfg_acc) apply_reg_write(cfg_if.index, cfg_if.data);
      if (pix_if.valid && pix_if.ready) begin
        if (pixels_due.size() == 0) begin
          errors++;
          if (errors <= 40)
            $display("%0t: unexpected pixel, expected none got %0h/%0d/%0h/%0b",
                     $time, pix_if.pixel_value, pix_if.plane, pix_if.plane_index,
                     pix_if.frame_last);
        end else begin
          want = pixels_due.pop_front();
          report_field("pixel_value", 32'(want.value), 32'(pix_if.pixel_value));
          report_field("plane", 32'(want.plane), 32'(pix_if.plane));
          report_field("plane_index", 32'(want.plane_index), 32'(pix_if.plane_index));
          report_field("frame_last", 32'(want.frame_last), 32'(pix_if.frame_last));
        end
      end
      if (byte_acc) unpack_byte(byte_if.data_byte);
    end
  end

  // Source driver: bytes, register writes and settle points from stim_q
  always @(negedge clk) begin
    stim_op_t op;
    if (!rst) begin
      if (byte_busy && byte_acc) begin
        byte_busy = 0;
        gap_left  = src_idling ? idle_len() : 0;
      end
      if (cfg_busy && cfg_acc) cfg_busy = 0;
      if (!byte_busy && !cfg_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() > 0) begin
          op = stim_q[0];
          case (op.kind)
            STIM_BYTE: begin
              void'(stim_q.pop_front());
              cur_byte  = op.value[7:0];
              byte_busy = 1;
            end
            STIM_REG: begin
              void'(stim_q.pop_front());
              cur_idx   = op.reg_idx;
              cur_value = op.value;
              cfg_busy  = 1;
            end
            default: begin
              if (pixels_due.size() != 0) begin
                settle_cnt = 0;
              end else if (settle_cnt < SETTLE_CYCLES) begin
                settle_cnt++;
              end else begin
                void'(stim_q.pop_front());
                settle_cnt = 0;
                src_idling = op.value[0];
                snk_stalls = op.value[1];
              end
            end
          endcase
        end
      end
    end
    byte_if.valid     <= byte_busy;
    byte_if.data_byte <= byte_busy ? cur_byte : byte_t'($urandom);
    cfg_if.valid      <= cfg_busy;
    cfg_if.index      <= cur_idx;
    cfg_if.data       <= cfg_busy ? cur_value : cfg_data_t'($urandom);
  end

  // Sink: random stalls on the pixel side
  always @(negedge clk) begin
    bit rdy;
    rdy = 1'b0;
    if (!rst) begin
      if (snk_stalls && stall_left > 0) begin
        stall_left--;
      end else begin
        rdy = 1'b1;
        if (snk_stalls) stall_left = idle_len();
      end
    end
    pix_if.ready <= rdy;
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned planned;
    int unsigned n;
    int unsigned pick;
    cfg_data_t   w;
    cfg_data_t   r;
    byte_t       b;
    cfg_data_t   wide_list[8];
    cfg_data_t   rows_list[6];

    wide_list = '{14'd0, 14'd1, 14'd2, 14'd3, 14'd8191, 14'd8192, 14'd8193, 14'd16383};
    rows_list = '{14'd0, 14'd1, 14'd2, 14'd8191, 14'd8192, 14'd16383};

    // Directed: reset sizes, all-ones and all-zero pixels
    push_byte(8'hFF); push_byte(8'h0F); push_byte(8'hF0);
    push_byte(8'h00); push_byte(8'hF0); push_byte(8'h0F);
    // Smallest frame after clamping: every pair ends the frame
    push_settle(3);
    push_reg(CFG_ROW_WIDTH, 14'd0);
    push_reg(CFG_FRAME_ROWS, 14'd0);
    push_byte(8'h12); push_byte(8'h34); push_byte(8'h56);
    push_byte(8'h9A); push_byte(8'hBC); push_byte(8'hDE);
    // Largest values clamp to the size limits
    push_settle(0);
    push_reg(CFG_ROW_WIDTH, 14'd16383);
    push_reg(CFG_FRAME_ROWS, 14'd16383);
    push_byte(8'hA5); push_byte(8'h5A); push_byte(8'hC3);
    push_byte(8'h3C); push_byte(8'h81); push_byte(8'h7E);
    // Shrink mid-row: column beyond new width wraps at the pair end
    push_settle(1);
    push_reg(CFG_ROW_WIDTH, 14'd5);
    push_reg(CFG_FRAME_ROWS, 14'd2);
    for (int i = 0; i < 9; i++) push_byte(byte_t'($urandom));
    planned = 27;

    // Random phases, mostly small frames so that row and frame ends are frequent
    while (planned < 1950) begin
      push_settle($urandom_range(0, 3));
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        w = wide_list[3'($urandom_range(0, 7))];
        r = rows_list[3'($urandom_range(0, 5))];
      end else begin
        w = cfg_data_t'($urandom_range(0, 24));
        r = cfg_data_t'($urandom_range(0, 7));
      end
      if ($urandom_range(0, 3) != 0) push_reg(CFG_ROW_WIDTH, w);
      if ($urandom_range(0, 3) != 0) push_reg(CFG_FRAME_ROWS, r);
      n = $urandom_range(24, 150);
      for (int i = 0; i < n; i++) begin
        b = byte_t'($urandom);
        if ($urandom_range(0, 9) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        push_byte(b);
      end
      planned += n;
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || byte_busy || cfg_busy || pixels_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (pixels_due.size() != 0) begin
      errors++;
      $display("%0t: %0d expected pixels never arrived", $time, pixels_due.size());
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30ms;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

// ===== raw12_unpack_bayer_plane_split.f =====
rtl/raw12_pkg.sv
rtl/raw12_ifs.sv
rtl/raw12_unpack_bayer_plane_split.sv
tb/tb_raw12_unpack_bayer_plane_split.sv
